// ===== design/urrhr_pkg.sv =====
// Shared types and constants for the UDP round-robin header rewriter.
`default_nettype none
package urrhr_pkg;

  localparam int HEADER_LEN = 42;

  // Request kinds carried through the queue
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_PORT = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FILTER  = 2'd0;
  localparam logic [1:0] CFG_SRC_OUT = 2'd1;
  localparam logic [1:0] CFG_MAC     = 2'd2;
  localparam logic [1:0] CFG_COUNT   = 2'd3;

  // Verdict codes
  localparam logic [1:0] VERDICT_PASS     = 2'd0;
  localparam logic [1:0] VERDICT_TX       = 2'd1;
  localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [3:0]  entry_slot;
    logic [31:0] entry_address;
    logic [15:0] entry_udp_port;
    logic [47:0] entry_hw_address;
    logic [15:0] port_number;
    logic        port_allow;
  } item_t;

endpackage
`default_nettype wire

// ===== design/udp_round_robin_header_rewriter.sv =====
// Top level of the UDP round-robin header rewriter.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | operation, frame byte/last, entry, port filter
//  out_    | output    | out_valid/out_ready | out_byte, out_last, out_verdict
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata (48 bits)
//
// After reset a clearing pass sweeps the 65536 port allow bits, one a cycle; only the
// two queue entries fill then. Table and filter requests apply as popped. Header bytes
// are taken one a cycle while the output is free; the 42nd starts judging (port read,
// qualify; a matching frame with backends adds a 64-step remainder unit, table read and
// checksum), then 42 bytes leave via header RAM read/write states. Later bytes stream
// one a cycle while output is free. A two-entry queue keeps input open on out_ready low.
`default_nettype none
module udp_round_robin_header_rewriter #(
  parameter int BACKEND_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_frame_byte,
  input  wire logic        in_frame_last,
  input  wire logic [3:0]  in_entry_slot,
  input  wire logic [31:0] in_entry_address,
  input  wire logic [15:0] in_entry_udp_port,
  input  wire logic [47:0] in_entry_hw_address,
  input  wire logic [15:0] in_filter_port_number,
  input  wire logic        in_filter_port_allow,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [1:0]       out_verdict
);

  logic             q_valid;
  logic             q_pop;
  urrhr_pkg::item_t q_item;

  urrhr_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_frame_byte         (in_frame_byte),
    .in_frame_last         (in_frame_last),
    .in_entry_slot         (in_entry_slot),
    .in_entry_address      (in_entry_address),
    .in_entry_udp_port     (in_entry_udp_port),
    .in_entry_hw_address   (in_entry_hw_address),
    .in_filter_port_number (in_filter_port_number),
    .in_filter_port_allow  (in_filter_port_allow),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop)
  );

  urrhr_back #(.BACKEND_SLOTS(BACKEND_SLOTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_verdict (out_verdict)
  );

endmodule
`default_nettype wire

// ===== design/urrhr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module urrhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 42
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/urrhr_front.sv =====
// Front end: accept requests, classify them and queue them for the back end.
`default_nettype none
module urrhr_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_operation,
  input  wire logic [7:0]           in_frame_byte,
  input  wire logic                 in_frame_last,
  input  wire logic [3:0]           in_entry_slot,
  input  wire logic [31:0]          in_entry_address,
  input  wire logic [15:0]          in_entry_udp_port,
  input  wire logic [47:0]          in_entry_hw_address,
  input  wire logic [15:0]          in_filter_port_number,
  input  wire logic                 in_filter_port_allow,
  output logic                      q_valid,
  output urrhr_pkg::item_t          q_item,
  input  wire logic                 q_pop
);

  urrhr_pkg::item_t slot_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  urrhr_pkg::item_t cls;
  logic             push;

  always_comb begin
    cls.kind             = in_operation;
    cls.frame_byte       = in_frame_byte;
    cls.frame_last       = in_frame_last;
    cls.entry_slot       = in_entry_slot;
    cls.entry_address    = in_entry_address;
    cls.entry_udp_port   = in_entry_udp_port;
    cls.entry_hw_address = in_entry_hw_address;
    cls.port_number      = in_filter_port_number;
    cls.port_allow       = in_filter_port_allow;
  end

  assign in_ready = (cnt_r != 2'd2);
  // drop unknown operations at the door
  assign push     = in_valid && in_ready && (cls.kind != urrhr_pkg::KIND_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= cls;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// ===== design/urrhr_back.sv =====
// Back end: header buffering, frame judging, backend selection and rewrite.
`default_nettype none
module urrhr_back #(
  parameter int BACKEND_SLOTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [47:0]          cfg_wdata,
  input  wire logic                 q_valid,
  input  urrhr_pkg::item_t          q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_last,
  output logic [1:0]                out_verdict
);

  localparam int BAW = (BACKEND_SLOTS > 1) ? $clog2(BACKEND_SLOTS) : 1;
  localparam logic [8:0] BS9 = 9'(BACKEND_SLOTS);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_RUN   = 4'd1;
  localparam logic [3:0] S_JPORT = 4'd2;
  localparam logic [3:0] S_JQUAL = 4'd3;
  localparam logic [3:0] S_JMOD  = 4'd4;
  localparam logic [3:0] S_JTAB  = 4'd5;
  localparam logic [3:0] S_JSUM  = 4'd6;
  localparam logic [3:0] S_ERD   = 4'd7;
  localparam logic [3:0] S_EWR   = 4'd8;

  logic [3:0]  state_r;
  logic [15:0] clr_r;
  logic [31:0] filter_r;
  logic [31:0] src_out_r;
  logic [47:0] bal_mac_r;
  logic [4:0]  count_r;
  logic [5:0]  pos_r;
  logic [63:0] pkts_r;
  logic [63:0] div_r;
  logic [5:0]  step_r;
  logic [4:0]  rem_r;
  logic [5:0]  e_r;
  logic [5:0]  n_r;
  logic        flast_r;
  logic [1:0]  verdict_r;
  logic        rw_r;
  logic [BACKEND_SLOTS-1:0] valid_r;
  logic [7:0]  b12_r, b13_r, b14_r, b23_r;
  logic [31:0] dip_r;
  logic [15:0] dport_r;
  logic [19:0] acc_r;
  logic [31:0] be_ip_r;
  logic [15:0] be_port_r;
  logic [47:0] be_mac_r;
  logic [15:0] cks_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic [1:0]  out_verdict_r;

  logic        out_free;
  logic        pop_byte, pop_load, pop_port;
  logic [8:0]  slot9;
  logic        load_ok;
  logic [8:0]  rem9;
  logic [BAW-1:0] tab_addr;
  logic [7:0]  hdr_q;
  logic        port_q;
  logic [95:0] tab_q;
  logic [95:0] entry;
  logic        port_we;
  logic [15:0] port_waddr;
  logic        port_wdata;
  logic        qual;
  logic [5:0]  mod_t;
  logic [20:0] sum;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [5:0]  off;
  logic [7:0]  wb;
  logic [63:0] pkts_inc;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == S_RUN) && q_valid && out_free;
  assign pop_byte = q_pop && (q_item.kind == urrhr_pkg::KIND_BYTE);
  assign pop_load = q_pop && (q_item.kind == urrhr_pkg::KIND_LOAD);
  assign pop_port = q_pop && (q_item.kind == urrhr_pkg::KIND_PORT);
  assign slot9    = 9'(q_item.entry_slot);
  assign load_ok  = slot9 < BS9;
  assign rem9     = 9'(rem_r);
  assign tab_addr = rem9[BAW-1:0];
  assign pkts_inc = pkts_r + 64'd1;

  // clearing pass owns the allow-bit write port after reset
  always_comb begin
    if (state_r == S_CLR) begin
      port_we    = 1'b1;
      port_waddr = clr_r;
      port_wdata = 1'b0;
    end else begin
      port_we    = pop_port;
      port_waddr = q_item.port_number;
      port_wdata = q_item.port_allow;
    end
  end

  urrhr_ram #(.WIDTH(8), .DEPTH(urrhr_pkg::HEADER_LEN)) u_hdr (
    .clk   (clk),
    .we    (pop_byte && (pos_r < 6'(urrhr_pkg::HEADER_LEN))),
    .waddr (pos_r),
    .wdata (q_item.frame_byte),
    .re    (state_r == S_ERD),
    .raddr (e_r),
    .rdata (hdr_q)
  );

  urrhr_ram #(.WIDTH(1), .DEPTH(65536)) u_allow (
    .clk   (clk),
    .we    (port_we),
    .waddr (port_waddr),
    .wdata (port_wdata),
    .re    (state_r == S_JPORT),
    .raddr (dport_r),
    .rdata (port_q)
  );

  urrhr_ram #(.WIDTH(96), .DEPTH(BACKEND_SLOTS)) u_tab (
    .clk   (clk),
    .we    (pop_load && load_ok),
    .waddr (slot9[BAW-1:0]),
    .wdata ({q_item.entry_address, q_item.entry_udp_port, q_item.entry_hw_address}),
    .re    (state_r == S_JTAB),
    .raddr (tab_addr),
    .rdata (tab_q)
  );

  assign entry = valid_r[tab_addr] ? tab_q : 96'd0;

  assign qual = (b12_r == 8'h08) && (b13_r == 8'h00) && (b14_r == 8'h45) &&
                (b23_r == 8'd17) && (dip_r == filter_r) && port_q;

  // one restoring step of the slot remainder, counter bits MSB first
  assign mod_t = {rem_r, div_r[63]} >= {1'b0, count_r} ?
                 {rem_r, div_r[63]} - {1'b0, count_r} : {rem_r, div_r[63]};

  always_comb begin
    sum   = 21'(acc_r) + 21'(src_out_r[31:16]) + 21'(src_out_r[15:0]) +
            21'(entry[95:80]) + 21'(entry[79:64]);
    fold1 = 17'(sum[15:0]) + 17'(sum[20:16]);
    fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
  end

  // rewritten byte at emit position
  always_comb begin
    wb  = hdr_q;
    off = 6'd0;
    if (rw_r) begin
      priority if (e_r < 6'd6) begin
        off = 6'd5 - e_r;
        wb  = 8'(be_mac_r >> {off[2:0], 3'b000});
      end else if (e_r < 6'd12) begin
        off = 6'd11 - e_r;
        wb  = 8'(bal_mac_r >> {off[2:0], 3'b000});
      end else if (e_r == 6'd24) begin
        wb = cks_r[15:8];
      end else if (e_r == 6'd25) begin
        wb = cks_r[7:0];
      end else if (e_r >= 6'd26 && e_r < 6'd30) begin
        off = 6'd29 - e_r;
        wb  = 8'(src_out_r >> {off[1:0], 3'b000});
      end else if (e_r >= 6'd30 && e_r < 6'd34) begin
        off = 6'd33 - e_r;
        wb  = 8'(be_ip_r >> {off[1:0], 3'b000});
      end else if (e_r == 6'd36) begin
        wb = be_port_r[15:8];
      end else if (e_r == 6'd37) begin
        wb = be_port_r[7:0];
      end else if (e_r == 6'd40 || e_r == 6'd41) begin
        wb = 8'd0;
      end else begin
        wb = hdr_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= 16'd0;
      filter_r    <= 32'd0;
      src_out_r   <= 32'd0;
      bal_mac_r   <= 48'd0;
      count_r     <= 5'd0;
      pos_r       <= 6'd0;
      pkts_r      <= 64'd0;
      verdict_r   <= urrhr_pkg::VERDICT_PASS;
      rw_r        <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          urrhr_pkg::CFG_FILTER:  filter_r  <= cfg_wdata[31:0];
          urrhr_pkg::CFG_SRC_OUT: src_out_r <= cfg_wdata[31:0];
          urrhr_pkg::CFG_MAC:     bal_mac_r <= cfg_wdata;
          urrhr_pkg::CFG_COUNT:   count_r   <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 16'd1;
          if (clr_r == 16'hffff) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (pop_load && load_ok) begin
            valid_r[slot9[BAW-1:0]] <= 1'b1;
          end
          if (pop_byte) begin
            if (pos_r >= 6'(urrhr_pkg::HEADER_LEN)) begin
              // header is out: stream the byte straight through
              out_valid_r   <= 1'b1;
              out_byte_r    <= q_item.frame_byte;
              out_last_r    <= q_item.frame_last;
              out_verdict_r <= verdict_r;
              if (q_item.frame_last) begin
                pos_r <= 6'd0;
              end
            end else begin
              pos_r <= pos_r + 6'd1;
              if (pos_r == 6'd12) b12_r <= q_item.frame_byte;
              if (pos_r == 6'd13) b13_r <= q_item.frame_byte;
              if (pos_r == 6'd14) b14_r <= q_item.frame_byte;
              if (pos_r == 6'd23) b23_r <= q_item.frame_byte;
              if (pos_r == 6'd30) dip_r[31:24] <= q_item.frame_byte;
              if (pos_r == 6'd31) dip_r[23:16] <= q_item.frame_byte;
              if (pos_r == 6'd32) dip_r[15:8]  <= q_item.frame_byte;
              if (pos_r == 6'd33) dip_r[7:0]   <= q_item.frame_byte;
              if (pos_r == 6'd36) dport_r[15:8] <= q_item.frame_byte;
              if (pos_r == 6'd37) dport_r[7:0]  <= q_item.frame_byte;
              if (pos_r == 6'd14) begin
                acc_r <= {4'd0, q_item.frame_byte, 8'd0};
              end else if (pos_r > 6'd14 && pos_r < 6'd24) begin
                acc_r <= acc_r + (pos_r[0] ? {12'd0, q_item.frame_byte} :
                                             {4'd0, q_item.frame_byte, 8'd0});
              end
              if (pos_r == 6'(urrhr_pkg::HEADER_LEN - 1)) begin
                flast_r <= q_item.frame_last;
                state_r <= S_JPORT;
              end else if (q_item.frame_last) begin
                // short frame: release held bytes untouched
                n_r       <= pos_r + 6'd1;
                flast_r   <= 1'b1;
                verdict_r <= urrhr_pkg::VERDICT_PASS;
                rw_r      <= 1'b0;
                e_r       <= 6'd0;
                state_r   <= S_ERD;
              end
            end
          end
        end
        S_JPORT: begin
          state_r <= S_JQUAL;
        end
        S_JQUAL: begin
          rw_r      <= 1'b0;
          verdict_r <= urrhr_pkg::VERDICT_PASS;
          n_r       <= 6'(urrhr_pkg::HEADER_LEN);
          e_r       <= 6'd0;
          if (qual) begin
            pkts_r <= pkts_inc;
            div_r  <= pkts_inc;
            step_r <= 6'd0;
            rem_r  <= 5'd0;
          end
          state_r <= (qual && count_r != 5'd0) ? S_JMOD : S_ERD;
        end
        S_JMOD: begin
          rem_r  <= mod_t[4:0];
          div_r  <= {div_r[62:0], 1'b0};
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) begin
            state_r <= S_JTAB;
          end
        end
        S_JTAB: begin
          state_r <= (rem9 < BS9) ? S_JSUM : S_ERD;
        end
        S_JSUM: begin
          be_ip_r   <= entry[95:64];
          be_port_r <= entry[63:48];
          be_mac_r  <= entry[47:0];
          cks_r     <= ~fold2[15:0];
          rw_r      <= 1'b1;
          verdict_r <= (src_out_r == filter_r) ? urrhr_pkg::VERDICT_TX :
                                                 urrhr_pkg::VERDICT_REDIRECT;
          state_r   <= S_ERD;
        end
        S_ERD: begin
          state_r <= S_EWR;
        end
        S_EWR: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_byte_r    <= wb;
            out_last_r    <= (e_r == n_r - 6'd1) ? flast_r : 1'b0;
            out_verdict_r <= verdict_r;
            e_r           <= e_r + 6'd1;
            if (e_r == n_r - 6'd1) begin
              pos_r   <= flast_r ? 6'd0 : 6'(urrhr_pkg::HEADER_LEN);
              state_r <= S_RUN;
            end else begin
              state_r <= S_ERD;
            end
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_last    = out_last_r;
  assign out_verdict = out_verdict_r;

endmodule
`default_nettype wire
